// ----- design/reed_solomon_encoder_top_assert.svh -----
// Assertion helpers for the Reed-Solomon encoder. Every use sits inside a module that
// has a clock named clk and an active-low reset named rst_n.
`ifndef REED_SOLOMON_ENCODER_TOP_ASSERT_SVH
`define REED_SOLOMON_ENCODER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define RS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// The consequent must hold in the cycle after the antecedent.
`define RS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define RS_ASSERT_SAME(label, ante, cons)
`define RS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/rs_enc_pkg.sv -----
package rs_enc_pkg;

  localparam int MAX_PARITY   = 32;
  localparam int CNT_W        = $clog2(MAX_PARITY + 1);
  localparam int SYM_W        = 8;
  localparam int CFG_W        = 6;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam logic [CFG_W-1:0] PARITY_RESET = 6'd16;
  localparam logic [8:0]       FIELD_POLY   = 9'h11d;

  // Register index, taken from paddr[2] (registers are 4 bytes apart).
  localparam logic REG_IDX_PARITY = 1'b0;

  typedef enum logic {
    ST_RUN,
    ST_DRAIN
  } enc_state_t;

  // Per-cycle command shared by every cell of the chain.
  typedef struct packed {
    logic enc;    // division step with the current feedback symbol
    logic shift;  // move remainder one cell up during the parity drain
    logic clr;    // zero remainder and generator
    logic bld;    // multiply generator by (x + root)
  } rs_cell_ctl_t;

  // Generator build control from the configuration block.
  typedef struct packed {
    logic             busy;
    logic             step;
    logic             clr;
    logic [SYM_W-1:0] root;
  } rs_bld_ctl_t;

  function automatic logic [SYM_W-1:0] gf_xtime(input logic [SYM_W-1:0] x);
    return {x[SYM_W-2:0], 1'b0} ^ (x[SYM_W-1] ? FIELD_POLY[SYM_W-1:0] : '0);
  endfunction

  function automatic logic [SYM_W-1:0] gf_mul(input logic [SYM_W-1:0] a,
                                              input logic [SYM_W-1:0] b);
    logic [SYM_W-1:0] acc;
    logic [SYM_W-1:0] x;
    acc = '0;
    x   = a;
    for (int k = 0; k < SYM_W; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

  // Zero acts as one; anything above the chain length saturates.
  function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > MAX_PARITY) begin
      r = CNT_W'(MAX_PARITY);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ----- design/reed_solomon_encoder_top.sv -----
// Systematic Reed-Solomon encoder over GF(256) (field polynomial 0x11d, generator roots
// 2^0 .. 2^(n-1), n = parity_count, 1 to 32, reset 16). Message symbols enter highest
// index first and are echoed one for one with tuser low; after the symbol that carries
// in_tlast, the n parity symbols follow highest index first with tuser high, the last
// of them with out_tlast. A message symbol is taken every cycle while the output is not
// stalled; after a last symbol the input holds off while the n parity symbols leave
// through the single output port. After reset, and after every write of parity_count,
// the generator is rebuilt and no symbol is accepted meanwhile; register writes are
// taken at any time but belong between codewords, and a write also clears the remainder.
`include "reed_solomon_encoder_top_assert.svh"
module reed_solomon_encoder_top import rs_enc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SYM_W-1:0]      in_tdata,     // [7:0] message_symbol
  input  logic                  in_tlast,     // message_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [SYM_W-1:0]      out_tdata,    // [7:0] code_symbol
  output logic                  out_tuser,    // [0] is_parity
  output logic                  out_tlast,    // codeword_last
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // The division register is kept top-aligned: remainder coefficient k lives in cell
  // k + MAX_PARITY - n, so the feedback always comes from the top cell. Cells below
  // the active window hold a zero generator and therefore a zero remainder, which also
  // lets the parity drain shift zeros in and leave the register cleared.

  logic [CNT_W-1:0] parity_count;
  rs_bld_ctl_t      bld;
  rs_cell_ctl_t     cell_ctl;

  logic [SYM_W-1:0] rem_w    [MAX_PARITY];
  logic [SYM_W-1:0] gen_w    [MAX_PARITY];
  logic [SYM_W-1:0] rem_lo_w [MAX_PARITY];
  logic [SYM_W-1:0] gen_hi_w [MAX_PARITY];
  logic [SYM_W-1:0] fb;

  enc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] drain_cnt_r, drain_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic             out_par_r, out_par_nxt;
  logic             out_last_r, out_last_nxt;
  logic             slot_free, in_acc, drain_load;

  rs_enc_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .parity_count (parity_count),
    .bld          (bld)
  );

  assign fb = in_tdata ^ rem_w[MAX_PARITY-1];

  assign cell_ctl.enc   = in_acc;
  assign cell_ctl.shift = drain_load;
  assign cell_ctl.clr   = bld.clr;
  assign cell_ctl.bld   = bld.step;

  // The monic top coefficient of the generator is implied above the last cell.
  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_chain
    if (j == 0) begin : g_bot
      assign rem_lo_w[j] = '0;
    end else begin : g_mid_lo
      assign rem_lo_w[j] = rem_w[j-1];
    end
    if (j == MAX_PARITY - 1) begin : g_top
      assign gen_hi_w[j] = SYM_W'(1);
    end else begin : g_mid_hi
      assign gen_hi_w[j] = gen_w[j+1];
    end
    rs_enc_cell u_cell (
      .clk    (clk),
      .ctl    (cell_ctl),
      .fb     (fb),
      .root   (bld.root),
      .rem_lo (rem_lo_w[j]),
      .gen_hi (gen_hi_w[j]),
      .rem    (rem_w[j]),
      .gen    (gen_w[j])
    );
  end

  // The output register frees its slot in the same cycle it is taken, so a new
  // request is accepted while the previous result is leaving.
  always_comb begin
    state_nxt     = state_r;
    drain_cnt_nxt = drain_cnt_r;
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_par_nxt   = out_par_r;
    out_last_nxt  = out_last_r;
    slot_free     = !out_valid_r || out_tready;
    in_tready     = (state_r == ST_RUN) && !bld.busy && slot_free;
    in_acc        = in_tvalid && in_tready;
    drain_load    = (state_r == ST_DRAIN) && slot_free;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_RUN: begin
        if (in_acc) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = in_tdata;
          out_par_nxt   = 1'b0;
          out_last_nxt  = 1'b0;
          if (in_tlast) begin
            state_nxt     = ST_DRAIN;
            drain_cnt_nxt = parity_count;
          end
        end
      end
      ST_DRAIN: begin
        if (drain_load) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = rem_w[MAX_PARITY-1];
          out_par_nxt   = 1'b1;
          out_last_nxt  = (drain_cnt_r == CNT_W'(1));
          drain_cnt_nxt = drain_cnt_r - CNT_W'(1);
          if (drain_cnt_r == CNT_W'(1)) begin
            state_nxt = ST_RUN;
          end
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      drain_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sym_r  <= out_sym_nxt;
    out_par_r  <= out_par_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tuser  = out_par_r;
  assign out_tlast  = out_last_r;

  `RS_ASSERT_NEXT(a_last_starts_drain, in_acc && in_tlast, state_r == ST_DRAIN)
  `RS_ASSERT_SAME(a_drain_count_live, state_r == ST_DRAIN, drain_cnt_r != '0)
  `RS_ASSERT_SAME(a_last_is_parity, out_valid_r && out_tlast, out_tuser)
  `RS_ASSERT_SAME(a_no_input_in_build, bld.busy, !in_tready)

endmodule

// ----- design/rs_enc_cell.sv -----
// One stage of the division register: a remainder byte and a generator byte.
// The single GF multiplier serves the division step and the generator build.
module rs_enc_cell import rs_enc_pkg::*; (
  input  logic             clk,
  input  rs_cell_ctl_t     ctl,
  input  logic [SYM_W-1:0] fb,
  input  logic [SYM_W-1:0] root,
  input  logic [SYM_W-1:0] rem_lo,
  input  logic [SYM_W-1:0] gen_hi,
  output logic [SYM_W-1:0] rem,
  output logic [SYM_W-1:0] gen
);

  logic [SYM_W-1:0] rem_r, rem_nxt;
  logic [SYM_W-1:0] gen_r, gen_nxt;
  logic [SYM_W-1:0] mul_a, mul_b, prod;

  always_comb begin
    mul_a = ctl.bld ? root : fb;
    mul_b = ctl.bld ? gen_hi : gen_r;
    prod  = gf_mul(mul_a, mul_b);
  end

  always_comb begin
    rem_nxt = rem_r;
    gen_nxt = gen_r;
    priority if (ctl.clr) begin
      rem_nxt = '0;
      gen_nxt = '0;
    end else if (ctl.enc) begin
      rem_nxt = rem_lo ^ prod;
    end else if (ctl.shift) begin
      rem_nxt = rem_lo;
    end else if (ctl.bld) begin
      gen_nxt = gen_r ^ prod;
    end else begin
      gen_nxt = gen_r;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    gen_r <= gen_nxt;
  end

  assign rem = rem_r;
  assign gen = gen_r;

endmodule

// ----- design/rs_enc_cfg.sv -----
// Register port and generator build sequencer. After reset or a write of the
// parity count, one clear cycle is followed by one build step per parity symbol.
module rs_enc_cfg import rs_enc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [CNT_W-1:0]      parity_count,
  output rs_bld_ctl_t           bld
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] bld_cnt_r, bld_cnt_nxt;
  logic [SYM_W-1:0] root_r, root_nxt;
  logic             clr_r, clr_nxt;
  logic             wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
              (cfg_paddr[CFG_ADDR_W-1] == REG_IDX_PARITY);

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1] == REG_IDX_PARITY) begin
      cfg_prdata = {{(CFG_DATA_W-CNT_W){1'b0}}, count_r};
    end
  end

  always_comb begin
    count_nxt   = count_r;
    bld_cnt_nxt = bld_cnt_r;
    root_nxt    = root_r;
    clr_nxt     = 1'b0;
    bld.clr     = clr_r;
    bld.step    = !clr_r && (bld_cnt_r != '0);
    bld.busy    = clr_r || (bld_cnt_r != '0);
    bld.root    = root_r;
    priority if (wr) begin
      count_nxt   = clamp_count(cfg_pwdata[CFG_W-1:0]);
      bld_cnt_nxt = clamp_count(cfg_pwdata[CFG_W-1:0]);
      root_nxt    = SYM_W'(1);
      clr_nxt     = 1'b1;
    end else if (bld.step) begin
      bld_cnt_nxt = bld_cnt_r - CNT_W'(1);
      root_nxt    = gf_xtime(root_r);
    end else begin
      root_nxt    = root_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= clamp_count(PARITY_RESET);
      bld_cnt_r <= clamp_count(PARITY_RESET);
      root_r    <= SYM_W'(1);
      clr_r     <= 1'b1;
    end else begin
      count_r   <= count_nxt;
      bld_cnt_r <= bld_cnt_nxt;
      root_r    <= root_nxt;
      clr_r     <= clr_nxt;
    end
  end

  assign parity_count = count_r;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import rs_enc_pkg::*;

  // Clock period and the overall time budget for the run. The slowest legal run
  // (every message one symbol long at 32 parity symbols, every result held up by
  // the longest sink stall) stays well under a quarter of this budget.
  localparam int CLK_PERIOD   = 12;
  localparam int LIMIT_CYCLES = 2000000;

  // Register map: parity_count is the only register. The next word is unmapped
  // and a write to it must leave the encoder alone.
  localparam logic [CFG_ADDR_W-1:0] PARITY_ADDR = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  // Cycles allowed after the last expected symbol before a register write or the
  // end of the run, so nothing still in flight can slip past the check.
  localparam int SETTLE_CYCLES = 4;
  localparam int FINAL_SETTLE = 40;

  localparam int RANDOM_SYMBOLS = 290;

  // One codeword symbol as it should leave the encoder.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             parity;
    logic             last;
  } code_sym_t;

  // Tracks the encoder's division register and generator, and the codeword
  // symbols that still have to come out, oldest first.
  class codeword_scoreboard;
    logic [SYM_W-1:0] gen_coef[MAX_PARITY];
    logic [SYM_W-1:0] remainder[MAX_PARITY];
    int               n_parity;
    code_sym_t        codeword_q[$];
    int               errors;

    function new();
      errors   = 0;
      n_parity = 16;
      rebuild();
    endfunction

    function logic [SYM_W-1:0] gf_times(logic [SYM_W-1:0] a, logic [SYM_W-1:0] b);
      logic [SYM_W:0]   x;
      logic [SYM_W-1:0] acc;
      x   = {1'b0, a};
      acc = '0;
      for (int k = 0; k < SYM_W; k++) begin
        if (b[k]) begin
          acc = acc ^ x[SYM_W-1:0];
        end
        x = x << 1;
        if (x[SYM_W]) begin
          x = x ^ FIELD_POLY;
        end
      end
      return acc;
    endfunction

    // Multiply out prod (x + 2^i) for i below n_parity and keep the low
    // coefficients; the leading one is implied. The remainder starts over.
    function void rebuild();
      logic [SYM_W-1:0] poly[MAX_PARITY+1];
      logic [SYM_W-1:0] root;
      foreach (poly[k]) poly[k] = '0;
      poly[0] = 8'h01;
      root    = 8'h01;
      for (int i = 0; i < n_parity; i++) begin
        for (int k = i + 1; k >= 1; k--) begin
          poly[k] = poly[k-1] ^ gf_times(poly[k], root);
        end
        poly[0] = gf_times(poly[0], root);
        root    = gf_times(root, 8'h02);
      end
      foreach (gen_coef[k]) gen_coef[k] = (k < n_parity) ? poly[k] : '0;
      foreach (remainder[k]) remainder[k] = '0;
    endfunction

    // Only the low six bits count; zero means one and anything above the
    // chain length saturates.
    function void write_count(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      int v;
      if (addr != PARITY_ADDR) begin
        return;
      end
      v = int'(data[CFG_W-1:0]);
      if (v == 0) begin
        n_parity = 1;
      end else if (v > MAX_PARITY) begin
        n_parity = MAX_PARITY;
      end else begin
        n_parity = v;
      end
      rebuild();
    endfunction

    function void note_request(logic [SYM_W-1:0] sym, logic msg_last);
      logic [SYM_W-1:0] fb;
      code_sym_t        c;
      c.sym    = sym;
      c.parity = 1'b0;
      c.last   = 1'b0;
      codeword_q = {codeword_q, c};
      fb = sym ^ remainder[n_parity-1];
      for (int k = n_parity - 1; k >= 1; k--) begin
        remainder[k] = remainder[k-1] ^ gf_times(fb, gen_coef[k]);
      end
      remainder[0] = gf_times(fb, gen_coef[0]);
      if (msg_last) begin
        for (int k = n_parity; k >= 1; k--) begin
          c.sym    = remainder[k-1];
          c.parity = 1'b1;
          c.last   = (k == 1);
          codeword_q = {codeword_q, c};
        end
        foreach (remainder[k]) remainder[k] = '0;
      end
    endfunction

    function void check_result(logic [SYM_W-1:0] sym, logic parity, logic cw_last);
      code_sym_t c;
      if (codeword_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected symbol: expected none, got %02h user %0b last %0b",
                 $time, sym, parity, cw_last);
        return;
      end
      c = codeword_q.pop_front();
      if (sym !== c.sym) begin
        errors++;
        $display("%0t: code_symbol mismatch: expected %02h, got %02h", $time, c.sym, sym);
      end
      if (parity !== c.parity) begin
        errors++;
        $display("%0t: is_parity mismatch: expected %0b, got %0b", $time, c.parity, parity);
      end
      if (cw_last !== c.last) begin
        errors++;
        $display("%0t: codeword_last mismatch: expected %0b, got %0b", $time, c.last, cw_last);
      end
    endfunction

    function int pending();
      return codeword_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SYM_W-1:0]      in_tdata = '0;     // [7:0] message_symbol
  logic                  in_tlast = 1'b0;   // message_last
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [SYM_W-1:0]      out_tdata;         // [7:0] code_symbol
  logic                  out_tuser;         // [0] is_parity
  logic                  out_tlast;         // codeword_last
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  codeword_scoreboard sb = new();

  // Pacing state for both sides. A burst count forces back-to-back requests on
  // the source side; the sink alternates between ready and stalled stretches.
  int unsigned src_burst = 0;
  int unsigned sink_hold = 0;
  int          random_sent = 0;

  reed_solomon_encoder_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Both handshakes are sampled here, in the active region of the edge, so the
  // values seen are the ones present at the edge. The input request is noted
  // before the output is checked, so a same-edge echo still finds its entry.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_request(in_tdata, in_tlast);
      end
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tuser, out_tlast);
      end
    end
  end

  // Sink back-pressure. Most stretches are short, a few stalls run long, and now
  // and then the sink stays ready for a long while so the parity drain runs at
  // full rate.
  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:4]: begin
          out_tready <= 1'b1;
          sink_hold  <= $urandom_range(40, 150);
        end
        [5:59]: begin
          out_tready <= 1'b1;
          sink_hold  <= $urandom_range(0, 7);
        end
        [60:89]: begin
          out_tready <= 1'b0;
          sink_hold  <= $urandom_range(0, 2);
        end
        default: begin
          out_tready <= 1'b0;
          sink_hold  <= $urandom_range(3, 19);
        end
      endcase
    end
  end

  // Idle cycles ahead of the next request: usually none, sometimes a few,
  // rarely many, with occasional bursts that never idle at all.
  function automatic int pick_gap();
    int r;
    if (src_burst != 0) begin
      src_burst--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      src_burst = $urandom_range(20, 60);
      return 0;
    end else if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 20);
  endfunction

  // Offer one message symbol and hold it until the encoder takes it. Returns in
  // the time step of the accepting edge with tvalid still high, so a following
  // request can go straight out without a bubble.
  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic msg_last);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sym;
    in_tlast  <= msg_last;
    do @(posedge clk); while (!in_tready);
  endtask

  // Send a message of random content; the final symbol carries the last flag
  // unless a truncated message is wanted.
  task automatic send_message(input int len, input logic closed);
    for (int i = 0; i < len; i++) begin
      send_symbol(SYM_W'($urandom_range(0, 255)), closed && (i == len - 1));
    end
  endtask

  // Stop offering requests and wait until every expected symbol has come out,
  // then give the encoder a few more cycles before anything else happens.
  task automatic wait_quiet(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Register write: a setup cycle, then the access cycle that completes on pready.
  // The encoder is idle here, so the model is updated right after the write.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_count(addr, data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Pick the next parity setting, biased toward the edges of the range and the
  // values that must be clamped.
  function automatic logic [CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 11))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd2;
      3:       return 32'd32;
      4:       return 32'd33;
      5:       return 32'd63;
      6:       return {26'($urandom_range(0, 32'h03ff_ffff)), 6'($urandom_range(1, 32))};
      default: return 32'($urandom_range(1, 32));
    endcase
  endfunction

  initial begin
    int len;
    int msgs;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, starting from the reset setting of 16 parity symbols.
    // All-zero, all-one and single-bit symbols in one message.
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h80, 1'b0);
    send_symbol(8'h01, 1'b1);
    // A message that is a single symbol.
    send_symbol(8'ha5, 1'b1);
    // Three symbols of a message, then a write of zero: the count becomes one and
    // the partial remainder is thrown away.
    send_symbol(8'h12, 1'b0);
    send_symbol(8'h34, 1'b0);
    send_symbol(8'h56, 1'b0);
    wait_quiet(SETTLE_CYCLES);
    cfg_write(PARITY_ADDR, 32'd0);
    send_symbol(8'hff, 1'b0);
    send_symbol(8'h00, 1'b1);
    // The largest count.
    wait_quiet(SETTLE_CYCLES);
    cfg_write(PARITY_ADDR, 32'd32);
    send_symbol(8'hff, 1'b1);
    send_symbol(8'h5a, 1'b0);
    send_symbol(8'hc3, 1'b1);
    // Counts past the bound saturate.
    wait_quiet(SETTLE_CYCLES);
    cfg_write(PARITY_ADDR, 32'd33);
    send_symbol(8'h01, 1'b1);
    wait_quiet(SETTLE_CYCLES);
    cfg_write(PARITY_ADDR, 32'd63);
    send_symbol(8'hfe, 1'b0);
    send_symbol(8'h7f, 1'b1);
    // A write to the unmapped word must not disturb the count of 32.
    wait_quiet(SETTLE_CYCLES);
    cfg_write(UNMAPPED_ADDR, 32'd5);
    send_symbol(8'h33, 1'b1);
    // Bits above the register width are dropped, leaving five.
    wait_quiet(SETTLE_CYCLES);
    cfg_write(PARITY_ADDR, 32'hffff_ffc5);
    send_symbol(8'h11, 1'b0);
    send_symbol(8'h22, 1'b0);
    send_symbol(8'h33, 1'b1);
    wait_quiet(SETTLE_CYCLES);
    cfg_write(PARITY_ADDR, 32'd1);
    send_symbol(8'h80, 1'b1);

    // Random part: phases of a few complete messages, most with a fresh parity
    // setting. Messages are mostly short, some long; now and then a phase ends
    // in a truncated message so the next write lands mid-codeword.
    while (random_sent < RANDOM_SYMBOLS) begin
      wait_quiet(SETTLE_CYCLES);
      if ($urandom_range(0, 9) == 0) begin
        cfg_write(UNMAPPED_ADDR, $urandom());
      end else begin
        cfg_write(PARITY_ADDR, pick_count());
      end
      msgs = $urandom_range(2, 6);
      for (int m = 0; m < msgs; m++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        send_message(len, 1'b1);
        random_sent += len;
      end
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 5);
        send_message(len, 1'b0);
        random_sent += len;
      end
    end

    // Close any message still open so its parity is checked too, then drain.
    send_message(1, 1'b1);
    wait_quiet(FINAL_SETTLE);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("%0t: run did not complete in time", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/rs_enc_pkg.sv
design/rs_enc_cell.sv
design/rs_enc_cfg.sv
design/reed_solomon_encoder_top.sv
bench/tb.sv
